FILE: hdl/particle_gravity_bounce_merge_step_top_assert.svh
// ----------------------------------------------------------------------------
// Particle step assertion macros
// Concurrent assertion wrappers shared by the particle step RTL. They
// compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_GRAVITY_BOUNCE_MERGE_STEP_TOP_ASSERT_SVH
`define PARTICLE_GRAVITY_BOUNCE_MERGE_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// expression must never be true out of reset
`define PGB_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PGB_ASSERT(lbl, prop)
`define PGB_NEVER(lbl, expr)
`endif
`endif

FILE: hdl/pgb_pkg.sv
// ----------------------------------------------------------------------------
// Particle step package
// Word types, codes, sequencer states and arithmetic unit widths.
// ----------------------------------------------------------------------------
package pgb_pkg;

  // input and result words
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [31:0]        other_mass;
    logic [23:0]        other_radius;
    logic               other_absorbed;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic [31:0]        mass_out;
    logic [23:0]        radius_out;
    logic               absorbed_other;
  } out_word_t;

  typedef enum logic [1:0] {
    OPC_ATTRACT = 2'd0,
    OPC_TICK    = 2'd1,
    OPC_MERGE   = 2'd2,
    OPC_NOP     = 2'd3
  } opc_e;

  // configuration register indexes
  localparam logic [3:0] CFG_START_X      = 4'd0;
  localparam logic [3:0] CFG_START_Y      = 4'd1;
  localparam logic [3:0] CFG_START_VX     = 4'd2;
  localparam logic [3:0] CFG_START_VY     = 4'd3;
  localparam logic [3:0] CFG_START_MASS   = 4'd4;
  localparam logic [3:0] CFG_START_RADIUS = 4'd5;
  localparam logic [3:0] CFG_SCREEN_W     = 4'd6;
  localparam logic [3:0] CFG_SCREEN_H     = 4'd7;

  // G = 6.67408 in Q16
  localparam logic [18:0] G_Q16 = 19'd437393;

  // shared unit widths
  localparam int HALF_W = 34;             // multiplier operand width
  localparam int SQ_W   = 2 * HALF_W;     // mul A operand and root input
  localparam int RES_W  = 3 * HALF_W;     // product / result register
  localparam int NUM_W  = 118;            // dividend
  localparam int QB     = 32;             // quotient bits incl. overflow bit
  localparam int DSH_W  = RES_W + QB - 1; // shifted divisor

  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_SQRT = 2'd1,
    UOP_DIV  = 2'd2
  } uop_e;

  typedef struct packed {
    logic start;
    uop_e op;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_WAIT, ST_FIN,
    ST_DIFF, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6, ST_A7,
    ST_A8, ST_A9,
    ST_M1, ST_M2, ST_M3, ST_M4,
    ST_T0, ST_T1, ST_T2, ST_T3
  } st_e;

endpackage

FILE: hdl/pgb_unit.sv
// ----------------------------------------------------------------------------
// Particle step shared arithmetic unit
// Multi-cycle multiply (two 34x34 partial products), bit-serial square
// root and restoring divide, one operation at a time.
// ----------------------------------------------------------------------------
`include "particle_gravity_bounce_merge_step_top_assert.svh"

module pgb_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pgb_pkg::unit_cmd_t          cmd_i,
  input  logic [pgb_pkg::NUM_W-1:0]   opa_i,
  input  logic [pgb_pkg::RES_W-1:0]   opb_i,
  output pgb_pkg::unit_sts_t          sts_o,
  output logic [pgb_pkg::RES_W-1:0]   res_o
);
  import pgb_pkg::*;

  localparam logic [5:0] LAST_MUL  = 6'd2;
  localparam logic [5:0] LAST_SQRT = 6'(HALF_W - 1);
  localparam logic [5:0] LAST_DIV  = 6'(QB - 1);

  logic              busy_q;
  logic [5:0]        cnt_q;
  uop_e              op_q;
  logic              last;
  logic [NUM_W-1:0]  x_q;
  logic [DSH_W-1:0]  y_q;
  logic [RES_W-1:0]  res_q;
  logic [SQ_W-1:0]   prod_q;
  logic [SQ_W:0]     sq_trial;
  logic              sq_ge;
  logic              dv_ge;

  // final step of the running operation
  always_comb begin
    unique case (op_q)
      UOP_MUL:  last = (cnt_q == LAST_MUL);
      UOP_SQRT: last = (cnt_q == LAST_SQRT);
      default:  last = (cnt_q == LAST_DIV);
    endcase
  end

  assign sq_trial = {1'b0, res_q[SQ_W-1:0]} + {1'b0, y_q[SQ_W-1:0]};
  assign sq_ge    = ({1'b0, x_q[SQ_W-1:0]} >= sq_trial);
  assign dv_ge    = (DSH_W'(x_q) >= y_q);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= UOP_MUL;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      op_q   <= cmd_i.op;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (last) busy_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_q <= '0;
      x_q   <= opa_i;
      unique case (cmd_i.op)
        UOP_MUL:  y_q <= DSH_W'(opb_i[HALF_W-1:0]);
        UOP_SQRT: y_q <= DSH_W'(1) << (SQ_W - 2);
        default:  y_q <= {opb_i, {(QB-1){1'b0}}};
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        UOP_MUL: begin
          // low partial, then high partial added 34 bits up
          if (cnt_q == 6'd0) begin
            prod_q <= x_q[HALF_W-1:0] * y_q[HALF_W-1:0];
          end else if (cnt_q == 6'd1) begin
            res_q  <= RES_W'(prod_q);
            prod_q <= x_q[SQ_W-1:HALF_W] * y_q[HALF_W-1:0];
          end else begin
            res_q <= res_q + (RES_W'(prod_q) << HALF_W);
          end
        end
        UOP_SQRT: begin
          // one root bit per step
          if (sq_ge) begin
            x_q   <= NUM_W'(x_q[SQ_W-1:0] - sq_trial[SQ_W-1:0]);
            res_q <= RES_W'((res_q[SQ_W-1:0] >> 1) + y_q[SQ_W-1:0]);
          end else begin
            res_q <= RES_W'(res_q[SQ_W-1:0] >> 1);
          end
          y_q <= y_q >> 2;
        end
        default: begin
          // one quotient bit per step, top bit flags overflow
          if (dv_ge) x_q <= x_q - y_q[NUM_W-1:0];
          res_q <= {res_q[RES_W-2:0], dv_ge};
          y_q   <= y_q >> 1;
        end
      endcase
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && last;
  assign res_o      = res_q;

  `PGB_NEVER(a_start_while_busy, cmd_i.start && busy_q)
  `PGB_ASSERT(a_start_sets_busy, cmd_i.start |=> busy_q)
  `PGB_ASSERT(a_done_clears_busy, sts_o.done |=> !busy_q)

endmodule

FILE: hdl/particle_gravity_bounce_merge_step_top.sv
// ----------------------------------------------------------------------------
// Particle step top level
// One 2D particle under gravity, with wall bounce and merging.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_data_i): one opcode word with the
//    other particle. in_ready_o is high only while the sequencer is idle.
//  - out channel (out_valid_o/out_ready_i/out_data_o): one result word per
//    input word, the particle state after the step, held in an output
//    register so a new input is taken while a result waits.
//  - cfg channel: writes start values (loaded into the state at once) and
//    the screen size; always ready; user writes only while idle, unchecked.
// Work per opcode on the shared multiply/root/divide unit, one op at a
//  time: attract takes a root, two divides and six multiplies; merge
//  takes up to five multiplies and a root; tick and no-op use no unit op.
//  in_ready_o returns with the result; one word is in work at a time.
// Reset: position, velocity and acceleration zero; mass, radius and screen size take defaults.
// Receiver stall: a finished result waits in the final state until the
//  output register frees up.
// ----------------------------------------------------------------------------
`include "particle_gravity_bounce_merge_step_top_assert.svh"

module particle_gravity_bounce_merge_step_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pgb_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pgb_pkg::out_word_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import pgb_pkg::*;

  localparam int NUM_SH = 2 * FRAC_BITS - 16;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -40'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [31:0] negsat(input logic signed [31:0] v);
    if (v == 32'sh8000_0000) return 32'sh7FFF_FFFF;
    else                     return -v;
  endfunction

  st_e                st_q, st_d, ret_q, ret_d;
  in_word_t           in_q, in_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [31:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [31:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [31:0]        mass_q, mass_d;
  logic [23:0]        radius_q, radius_d;
  logic [11:0]        scr_w_q, scr_w_d, scr_h_q, scr_h_d;
  logic [31:0]        adx_q, adx_d, ady_q, ady_d;
  logic               sgnx_q, sgnx_d, sgny_q, sgny_d;
  logic [65:0]        s_q, s_d;
  logic [RES_W-1:0]   den_q, den_d;
  logic [50:0]        k_q, k_d;
  logic               absorbed_q, absorbed_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  unit_cmd_t          cmd;
  unit_sts_t          sts;
  logic [NUM_W-1:0]   opa;
  logic [RES_W-1:0]   opb;
  logic [RES_W-1:0]   res;

  // derived values
  logic [32:0]        dx, dy;
  logic [65:0]        s_sum;
  logic [24:0]        sr;
  logic [30:0]        quo_mag;
  logic signed [39:0] mag40, accx_new, accy_new;
  logic signed [39:0] r40, one_f, wx, wy, px40, py40;
  logic [32:0]        mass_sum;
  logic [33:0]        root;
  logic               in_fire, cfg_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  assign dx       = {in_q.other_x[31], in_q.other_x} - {pos_x_q[31], pos_x_q};
  assign dy       = {in_q.other_y[31], in_q.other_y} - {pos_y_q[31], pos_y_q};
  assign s_sum    = s_q + 66'(res[63:0]);
  assign sr       = 25'(radius_q) + 25'(in_q.other_radius);
  assign quo_mag  = res[QB-1] ? 31'h7FFF_FFFF : res[QB-2:0];
  assign mag40    = 40'(quo_mag);
  assign accx_new = 40'(acc_x_q) + (sgnx_q ? -mag40 : mag40);
  assign accy_new = 40'(acc_y_q) + (sgny_q ? -mag40 : mag40);
  assign r40      = 40'(radius_q);
  assign one_f    = 40'sd1 <<< FRAC_BITS;
  assign wx       = 40'(scr_w_q) <<< FRAC_BITS;
  assign wy       = 40'(scr_h_q) <<< FRAC_BITS;
  assign px40     = 40'(pos_x_q);
  assign py40     = 40'(pos_y_q);
  assign mass_sum = {1'b0, mass_q} + {1'b0, in_q.other_mass};
  assign root     = res[33:0];

  // sequencer
  always_comb begin
    st_d        = st_q;
    ret_d       = ret_q;
    in_d        = in_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    vel_x_d     = vel_x_q;
    vel_y_d     = vel_y_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    mass_d      = mass_q;
    radius_d    = radius_q;
    scr_w_d     = scr_w_q;
    scr_h_d     = scr_h_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    sgnx_d      = sgnx_q;
    sgny_d      = sgny_q;
    s_d         = s_q;
    den_d       = den_q;
    k_d         = k_q;
    absorbed_d  = absorbed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd.start   = 1'b0;
    cmd.op      = UOP_MUL;
    opa         = '0;
    opb         = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          in_d       = in_data_i;
          absorbed_d = 1'b0;
          unique case (opc_e'(in_data_i.opcode))
            OPC_ATTRACT: st_d = ST_DIFF;
            OPC_TICK:    st_d = ST_T0;
            OPC_MERGE:   st_d = in_data_i.other_absorbed ? ST_FIN : ST_DIFF;
            OPC_NOP:     st_d = ST_FIN;
          endcase
        end
      end
      ST_WAIT: begin
        if (sts.done) st_d = ret_q;
      end
      // distance magnitudes and signs
      ST_DIFF: begin
        sgnx_d = dx[32];
        sgny_d = dy[32];
        adx_d  = dx[32] ? 32'(-dx) : dx[31:0];
        ady_d  = dy[32] ? 32'(-dy) : dy[31:0];
        st_d   = ST_A0;
      end
      ST_A0: begin
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(adx_q);
        opb = RES_W'(adx_q);
        st_d = ST_WAIT; ret_d = ST_A1;
      end
      ST_A1: begin
        s_d = 66'(res[63:0]);
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(ady_q);
        opb = RES_W'(ady_q);
        st_d = ST_WAIT; ret_d = ST_A2;
      end
      // squared distance ready
      ST_A2: begin
        s_d = s_sum;
        if (opc_e'(in_q.opcode) == OPC_MERGE) begin
          cmd = '{start: 1'b1, op: UOP_MUL};
          opa = NUM_W'(sr);
          opb = RES_W'(sr);
          st_d = ST_WAIT; ret_d = ST_M1;
        end else if (s_sum == '0) begin
          st_d = ST_FIN;
        end else begin
          cmd = '{start: 1'b1, op: UOP_SQRT};
          opa = NUM_W'(s_sum);
          st_d = ST_WAIT; ret_d = ST_A3;
        end
      end
      ST_A3: begin
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(s_q);
        opb = RES_W'(root);
        st_d = ST_WAIT; ret_d = ST_A4;
      end
      ST_A4: begin
        den_d = res;
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(in_q.other_mass);
        opb = RES_W'(G_Q16);
        st_d = ST_WAIT; ret_d = ST_A5;
      end
      ST_A5: begin
        k_d = res[50:0];
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(res[50:0]);
        opb = RES_W'(adx_q);
        st_d = ST_WAIT; ret_d = ST_A6;
      end
      ST_A6: begin
        cmd = '{start: 1'b1, op: UOP_DIV};
        opa = NUM_W'(res) << NUM_SH;
        opb = den_q;
        st_d = ST_WAIT; ret_d = ST_A7;
      end
      ST_A7: begin
        acc_x_d = sat32(accx_new);
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(k_q);
        opb = RES_W'(ady_q);
        st_d = ST_WAIT; ret_d = ST_A8;
      end
      ST_A8: begin
        cmd = '{start: 1'b1, op: UOP_DIV};
        opa = NUM_W'(res) << NUM_SH;
        opb = den_q;
        st_d = ST_WAIT; ret_d = ST_A9;
      end
      ST_A9: begin
        acc_y_d = sat32(accy_new);
        st_d    = ST_FIN;
      end
      // overlap test against the summed radii
      ST_M1: begin
        if (RES_W'(s_q) <= res) begin
          cmd = '{start: 1'b1, op: UOP_MUL};
          opa = NUM_W'(radius_q);
          opb = RES_W'(radius_q);
          st_d = ST_WAIT; ret_d = ST_M2;
        end else begin
          st_d = ST_FIN;
        end
      end
      ST_M2: begin
        s_d = 66'(res[47:0]);
        cmd = '{start: 1'b1, op: UOP_MUL};
        opa = NUM_W'(in_q.other_radius);
        opb = RES_W'(in_q.other_radius);
        st_d = ST_WAIT; ret_d = ST_M3;
      end
      ST_M3: begin
        cmd = '{start: 1'b1, op: UOP_SQRT};
        opa = NUM_W'(s_q) + NUM_W'(res[47:0]);
        st_d = ST_WAIT; ret_d = ST_M4;
      end
      ST_M4: begin
        radius_d   = (root > 34'hFF_FFFF) ? 24'hFF_FFFF : root[23:0];
        mass_d     = mass_sum[32] ? 32'hFFFF_FFFF : mass_sum[31:0];
        absorbed_d = 1'b1;
        st_d       = ST_FIN;
      end
      // tick: velocity, position, then the two wall tests
      ST_T0: begin
        vel_x_d = sat32(40'(vel_x_q) + 40'(acc_x_q));
        vel_y_d = sat32(40'(vel_y_q) + 40'(acc_y_q));
        st_d    = ST_T1;
      end
      ST_T1: begin
        pos_x_d = sat32(px40 + 40'(vel_x_q));
        pos_y_d = sat32(py40 + 40'(vel_y_q));
        acc_x_d = '0;
        acc_y_d = '0;
        st_d    = ST_T2;
      end
      ST_T2: begin
        if (px40 + r40 >= wx) begin
          pos_x_d = sat32(wx - r40 - one_f);
          vel_x_d = negsat(vel_x_q);
        end
        if (py40 + r40 >= wy) begin
          pos_y_d = sat32(wy - r40 - one_f);
          vel_y_d = negsat(vel_y_q);
        end
        st_d = ST_T3;
      end
      ST_T3: begin
        if (px40 - r40 <= 40'sd0) begin
          pos_x_d = 32'(radius_q);
          vel_x_d = negsat(vel_x_q);
        end
        if (py40 - r40 <= 40'sd0) begin
          pos_y_d = 32'(radius_q);
          vel_y_d = negsat(vel_y_q);
        end
        st_d = ST_FIN;
      end
      // hand the state to the output register
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.pos_x_out      = pos_x_q;
          out_d.pos_y_out      = pos_y_q;
          out_d.vel_x_out      = vel_x_q;
          out_d.vel_y_out      = vel_y_q;
          out_d.mass_out       = mass_q;
          out_d.radius_out     = radius_q;
          out_d.absorbed_other = absorbed_q;
          st_d                 = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // configuration writes load the state directly
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_START_X:      pos_x_d  = cfg_data_i;
        CFG_START_Y:      pos_y_d  = cfg_data_i;
        CFG_START_VX:     vel_x_d  = cfg_data_i;
        CFG_START_VY:     vel_y_d  = cfg_data_i;
        CFG_START_MASS:   mass_d   = cfg_data_i;
        CFG_START_RADIUS: radius_d = cfg_data_i[23:0];
        CFG_SCREEN_W:     scr_w_d  = cfg_data_i[11:0];
        CFG_SCREEN_H:     scr_h_d  = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // control and particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ret_q       <= ST_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      mass_q      <= 32'd65536;
      radius_q    <= 24'd327680;
      scr_w_q     <= 12'd800;
      scr_h_q     <= 12'd600;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ret_q       <= ret_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      vel_x_q     <= vel_x_d;
      vel_y_q     <= vel_y_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      mass_q      <= mass_d;
      radius_q    <= radius_d;
      scr_w_q     <= scr_w_d;
      scr_h_q     <= scr_h_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    sgnx_q     <= sgnx_d;
    sgny_q     <= sgny_d;
    s_q        <= s_d;
    den_q      <= den_d;
    k_q        <= k_d;
    absorbed_q <= absorbed_d;
    out_q      <= out_d;
  end

  pgb_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  `PGB_NEVER(a_unit_busy_idle, sts.busy && (st_q == ST_IDLE))
  `PGB_ASSERT(a_accept_leaves_idle, in_fire |=> (st_q != ST_IDLE))
  `PGB_ASSERT(a_tick_clears_acc, (st_q == ST_T1) |=> (acc_x_q == '0 && acc_y_q == '0))

endmodule
